// ===== src/impq_pkg.sv =====
`default_nettype none
package impq_pkg;
    localparam int KEY_W = 16;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DEC  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [KEY_W-1:0] key;
    } t_entry;
endpackage
`default_nettype wire

// ===== src/indexed_min_heap_priority_queue.sv =====
// channel | signals                                                   | side
// request | i_valid o_stall i_op i_node_row i_node_col i_cost_key      | in
// result  | o_valid i_stall o_status o_min_* o_entry_count             | out
// One request at a time. Push or decrease-key: S_LOOK and S_SLOT, then S_UPCK
// and S_UPRD per level sifted up. Pop: S_POP and S_LAST, then S_DNRD, S_DNCK
// and S_DNC2 per level sifted down. Empty pop and unused op go straight to S_OUT.
// After reset a clearing pass writes zero to every position map entry
// while o_stall is high.
// The result register holds while o_valid and i_stall are high; a finished request
// waits in S_OUT until it frees up. The next request is taken once S_IDLE returns.
`default_nettype none
module indexed_min_heap_priority_queue #(
    parameter int HEAP_DEPTH = 1024,
    parameter int GRID_ROWS  = 64,
    parameter int GRID_COLS  = 64
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [1:0]                  i_op,
    input  wire  [5:0]                  i_node_row,
    input  wire  [5:0]                  i_node_col,
    input  wire  [15:0]                 i_cost_key,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [1:0]                  o_status,
    output logic [5:0]                  o_min_row,
    output logic [5:0]                  o_min_col,
    output logic [15:0]                 o_min_key,
    output logic [$clog2(HEAP_DEPTH+1)-1:0] o_entry_count
);
    import impq_pkg::*;

    localparam int CW    = $clog2(HEAP_DEPTH + 1);
    localparam int MAPN  = GRID_ROWS * GRID_COLS;
    localparam int MW    = (MAPN > 1) ? $clog2(MAPN) : 1;
    localparam int HW    = $clog2(HEAP_DEPTH + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LOOK = 4'd2;
    localparam logic [3:0] S_SLOT = 4'd3;
    localparam logic [3:0] S_UPRD = 4'd4;
    localparam logic [3:0] S_UPCK = 4'd5;
    localparam logic [3:0] S_DNRD = 4'd6;
    localparam logic [3:0] S_DNCK = 4'd7;
    localparam logic [3:0] S_DNC2 = 4'd8;
    localparam logic [3:0] S_POP  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_LAST = 4'd11;

    t_entry        r_heap [HEAP_DEPTH+1];
    logic [HW-1:0] r_map  [MAPN];

    logic [3:0]    r_state;
    logic [MW-1:0] r_clr;
    logic [CW-1:0] r_count;
    logic [1:0]    r_op;
    t_entry        r_req;
    t_entry        r_mover;
    logic [HW-1:0] r_slot;
    logic [1:0]    r_status;
    t_entry        r_min;

    // heap port
    logic          h_we;
    logic [HW-1:0] h_waddr, h_raddr;
    t_entry        h_wdata, r_hq;
    // map port
    logic          m_we;
    logic [MW-1:0] m_waddr, m_raddr;
    logic [HW-1:0] m_wdata, r_mq;
    t_entry        r_kid;

    always_ff @(posedge i_clk) begin
        if (h_we) r_heap[h_waddr] <= h_wdata;
        r_hq <= r_heap[h_raddr];
        if (m_we) r_map[m_waddr] <= m_wdata;
        r_mq <= r_map[m_raddr];
    end

    function automatic logic [MW-1:0] midx(t_entry e);
        logic [23:0] p;
        p = 24'(e.row) * 24'(GRID_COLS) + 24'(e.col);
        return p[MW-1:0];
    endfunction

    logic [HW:0] kid1;
    assign kid1 = {r_slot, 1'b0};

    logic [3:0]    n_state;
    logic [HW-1:0] n_slot;
    t_entry        n_mover;
    logic [CW-1:0] n_count;
    logic [1:0]    n_status;
    t_entry        n_min;
    t_entry        n_kid;
    logic          in_acc, in_grid;
    t_entry        in_req;

    assign in_req  = '{row: i_node_row, col: i_node_col, key: i_cost_key};
    assign in_acc  = i_valid && !o_stall;
    assign in_grid = (32'(r_req.row) < 32'(GRID_ROWS)) && (32'(r_req.col) < 32'(GRID_COLS));
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_slot = r_slot; n_mover = r_mover; n_count = r_count;
        n_status = r_status; n_min = r_min; n_kid = r_kid;
        h_we = 1'b0; h_waddr = r_slot; h_wdata = r_mover; h_raddr = r_slot;
        m_we = 1'b0; m_waddr = midx(r_mover); m_wdata = r_slot; m_raddr = midx(r_req);
        case (r_state)
            S_CLR: begin
                m_we = 1'b1; m_waddr = r_clr; m_wdata = '0;
                if (32'(r_clr) == MAPN - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_status = ST_OK; n_min = '0;
                m_raddr = midx(in_req);
                if (in_acc) begin
                    if (i_op == OP_POP) begin
                        h_raddr = HW'(1);
                        n_state = (r_count == 0) ? S_OUT : S_POP;
                        if (r_count == 0) n_status = ST_EMPTY;
                    end else if (i_op == OP_PUSH || i_op == OP_DEC) begin
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_LOOK: begin
                if (!in_grid) begin
                    n_status = ST_ABSENT; n_state = S_OUT;
                end else n_state = S_SLOT;
                h_raddr = r_mq;
                n_slot = r_mq;
            end
            S_SLOT: begin
                if (r_slot >= 1 && CW'(r_slot) <= r_count) begin
                    if (r_req.key < r_hq.key) begin
                        n_mover = r_hq; n_mover.key = r_req.key;
                        h_raddr = r_slot >> 1;
                        n_state = S_UPCK;
                    end else n_state = S_OUT;
                end else if (r_op == OP_DEC) begin
                    n_status = ST_ABSENT; n_state = S_OUT;
                end else if (32'(r_count) >= HEAP_DEPTH) begin
                    n_status = ST_FULL; n_state = S_OUT;
                end else begin
                    n_count = r_count + 1'b1;
                    n_slot  = HW'(r_count + 1'b1);
                    n_mover = r_req;
                    h_raddr = HW'(r_count + 1'b1) >> 1;
                    n_state = S_UPCK;
                end
            end
            S_UPCK: begin
                // r_hq holds parent of r_slot
                if (r_slot > 1 && r_mover.key < r_hq.key) begin
                    h_we = 1'b1; h_waddr = r_slot; h_wdata = r_hq;
                    m_we = 1'b1; m_waddr = midx(r_hq); m_wdata = r_slot;
                    n_slot = r_slot >> 1;
                    n_state = S_UPRD;
                end else begin
                    h_we = 1'b1; m_we = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_UPRD: begin
                h_raddr = r_slot >> 1;
                n_state = S_UPCK;
            end
            S_POP: begin
                n_min = r_hq;
                m_we = 1'b1; m_waddr = midx(r_hq); m_wdata = '0;
                if (r_count == 1) begin
                    n_count = '0; n_state = S_OUT;
                end else begin
                    h_raddr = HW'(r_count);
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_mover = r_hq;
                n_count = r_count - 1'b1;
                n_slot = HW'(1);
                n_state = S_DNRD;
            end
            S_DNRD: begin
                if ({1'b0, r_slot} > (HW+1)'(r_count >> 1)) begin
                    h_we = 1'b1; m_we = 1'b1; n_state = S_OUT;
                end else begin
                    h_raddr = kid1[HW-1:0];
                    n_state = S_DNCK;
                end
            end
            S_DNCK: begin
                n_kid = r_hq;
                h_raddr = kid1[HW-1:0] + 1'b1;
                n_state = S_DNC2;
            end
            S_DNC2: begin
                n_kid = r_kid;
                n_slot = kid1[HW-1:0];
                if (CW'(kid1) < r_count && r_hq.key < r_kid.key) begin
                    n_kid = r_hq; n_slot = kid1[HW-1:0] + 1'b1;
                end
                if (n_kid.key < r_mover.key) begin
                    h_we = 1'b1; h_waddr = r_slot; h_wdata = n_kid;
                    m_we = 1'b1; m_waddr = midx(n_kid); m_wdata = r_slot;
                    n_state = S_DNRD;
                end else begin
                    n_slot = r_slot;
                    h_we = 1'b1; m_we = 1'b1; n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!(o_valid && i_stall)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_count <= '0; o_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (r_state == S_OUT && !(o_valid && i_stall)) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot; r_mover <= n_mover; r_status <= n_status; r_min <= n_min;
        r_kid <= n_kid;
        if (in_acc) begin
            r_op <= i_op;
            r_req <= in_req;
        end
        if (r_state == S_OUT && !(o_valid && i_stall)) begin
            o_status <= r_status; o_min_row <= r_min.row; o_min_col <= r_min.col;
            o_min_key <= r_min.key; o_entry_count <= r_count;
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= HEAP_DEPTH) else $error("count overflow");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE) else $error("accept without work");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_entry_count)) else $error("result lost");
endmodule
`default_nettype wire
